// ===== src/encoder_button_event_classifier_top_macros.svh =====
// assertion macros shared by the encoder and button event classifier
`ifndef ENCODER_BUTTON_EVENT_CLASSIFIER_TOP_MACROS_SVH
`define ENCODER_BUTTON_EVENT_CLASSIFIER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// property holds at every edge outside reset
`define EBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the cycle after
`define EBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define EBC_ASSERT(label, prop, msg)
`define EBC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== src/ebc_pkg.sv =====
// shared types and constants of the encoder and button event classifier
package ebc_pkg;

  // event sources
  typedef enum logic [1:0] {
    CMD_ENCODER = 2'd0,
    CMD_SWITCH  = 2'd1,
    CMD_POWER   = 2'd2
  } cmd_t;

  // result event codes
  typedef enum logic [2:0] {
    EV_CW        = 3'd0,
    EV_CCW       = 3'd1,
    EV_CLICK     = 3'd2,
    EV_LONG      = 3'd3,
    EV_PWR_PRESS = 3'd4,
    EV_PWR_LONG  = 3'd5
  } event_code_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ENC_DEBOUNCE   = 2'd0,
    REG_PRESS_DEBOUNCE = 2'd1,
    REG_SWITCH_LONG    = 2'd2,
    REG_POWER_LONG     = 2'd3
  } cfg_reg_t;

  localparam int CFG_W = 16;
  // a 16-bit millisecond count times 1000 fits in 26 bits
  localparam int THR_W = 26;
  localparam int MUL_W = 10;
  localparam logic [MUL_W-1:0] US_PER_MS = 10'd1000;

  // reset values, thresholds already scaled to microseconds
  localparam logic [CFG_W-1:0] ENC_DEBOUNCE_RST = 16'd2000;
  localparam logic [THR_W-1:0] PRESS_THR_RST    = 26'd30000;
  localparam logic [THR_W-1:0] SWITCH_THR_RST   = 26'd800000;
  localparam logic [THR_W-1:0] POWER_THR_RST    = 26'd2000000;

  // what one request does to the state and the result channel
  typedef struct packed {
    logic        res_valid;
    event_code_t event_code;
    logic        sleep;
    logic        pulse_load;
    logic        sw_load;
    logic        sw_clear;
    logic        pw_load;
    logic        pw_clear;
    logic        stop;
  } ebc_action_t;

endpackage

// ===== src/ebc_classify.sv =====
// combinational classification of one pin event against the stored times
module ebc_classify
  import ebc_pkg::*;
#(
  parameter int TIME_WIDTH = 48
) (
  input  logic [1:0]            cmd,
  input  logic                  level,
  input  logic [TIME_WIDTH-1:0] now,
  input  logic [TIME_WIDTH-1:0] last_pulse,
  input  logic [TIME_WIDTH-1:0] sw_press,
  input  logic [TIME_WIDTH-1:0] pw_press,
  input  logic                  stopped,
  input  logic [CFG_W-1:0]      enc_debounce,
  input  logic [THR_W-1:0]      press_thr,
  input  logic [THR_W-1:0]      switch_thr,
  input  logic [THR_W-1:0]      power_thr,
  output ebc_action_t           act
);

  logic [TIME_WIDTH-1:0] pulse_gap;
  logic [TIME_WIDTH-1:0] sw_hold;
  logic [TIME_WIDTH-1:0] pw_hold;
  logic                  pulse_ok;
  logic                  sw_ok;
  logic                  pw_ok;
  logic                  sw_long;
  logic                  pw_long;

  // elapsed times; hold in ms >= n is the same as hold in us >= n*1000
  assign pulse_gap = now - last_pulse;
  assign sw_hold   = now - sw_press;
  assign pw_hold   = now - pw_press;

  assign pulse_ok = (now >= last_pulse) &&
                    (pulse_gap >= {{(TIME_WIDTH-CFG_W){1'b0}}, enc_debounce});
  assign sw_ok    = (sw_press != '0) && (now >= sw_press) &&
                    (sw_hold >= {{(TIME_WIDTH-THR_W){1'b0}}, press_thr});
  assign pw_ok    = (pw_press != '0) && (now >= pw_press) &&
                    (pw_hold >= {{(TIME_WIDTH-THR_W){1'b0}}, press_thr});
  assign sw_long  = sw_hold >= {{(TIME_WIDTH-THR_W){1'b0}}, switch_thr};
  assign pw_long  = pw_hold >= {{(TIME_WIDTH-THR_W){1'b0}}, power_thr};

  // decode the event source
  always_comb begin
    act = '0;
    act.event_code = EV_CW;
    if (!stopped) begin
      case (cmd_t'(cmd))
        CMD_ENCODER: begin
          if (pulse_ok) begin
            act.res_valid  = 1'b1;
            act.pulse_load = 1'b1;
            act.event_code = level ? EV_CW : EV_CCW;
          end
        end
        CMD_SWITCH: begin
          if (!level) begin
            act.sw_load = 1'b1;
          end else begin
            act.sw_clear   = 1'b1;
            act.res_valid  = sw_ok;
            act.event_code = sw_long ? EV_LONG : EV_CLICK;
          end
        end
        CMD_POWER: begin
          if (!level) begin
            act.pw_load = 1'b1;
          end else begin
            act.pw_clear   = 1'b1;
            act.res_valid  = pw_ok;
            act.event_code = pw_long ? EV_PWR_LONG : EV_PWR_PRESS;
            act.sleep      = pw_ok && pw_long;
            act.stop       = pw_ok && pw_long;
          end
        end
        default: begin
          act = '0;
        end
      endcase
    end
  end

endmodule

// ===== src/encoder_button_event_classifier_top.sv =====
// encoder and button event classifier: top level with request and result registers
// Takes one timestamped pin request per clock cycle, sustained while the result
// register is not stalled. A request is captured in an input register, classified
// combinationally against the stored pulse and press times, and its result (if
// any) lands in the output register when the request leaves the input register;
// requests that give no result just update state. The single compare stage also
// updates the stored times, so back-to-back requests always see the state left by
// the one before. Button holds are compared in microseconds against millisecond
// thresholds that are scaled by 1000 when the configuration register is written.
// After a power long press every request is consumed without a result until reset.
module encoder_button_event_classifier_top
  import ebc_pkg::*;
#(
  parameter int TIME_WIDTH = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_cmd,
  input  logic                  in_pin_level,
  input  logic [TIME_WIDTH-1:0] in_time_us,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_event_code,
  output logic                  out_sleep_request,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

`include "encoder_button_event_classifier_top_macros.svh"

  logic                  in_valid_r;
  logic [1:0]            in_cmd_r;
  logic                  in_level_r;
  logic [TIME_WIDTH-1:0] in_time_r;

  logic [CFG_W-1:0]      enc_debounce_r;
  logic [THR_W-1:0]      press_thr_r;
  logic [THR_W-1:0]      switch_thr_r;
  logic [THR_W-1:0]      power_thr_r;
  logic [THR_W-1:0]      thr_nxt;

  logic [TIME_WIDTH-1:0] last_pulse_r;
  logic [TIME_WIDTH-1:0] sw_press_r;
  logic [TIME_WIDTH-1:0] pw_press_r;
  logic                  stopped_r;

  logic                  out_valid_r;
  event_code_t           out_code_r;
  logic                  out_sleep_r;

  ebc_action_t           act;
  logic                  adv;

  // stage handshake
  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_cmd_r   <= in_cmd;
      in_level_r <= in_pin_level;
      in_time_r  <= in_time_us;
    end
  end

  // configuration, hold thresholds scaled to microseconds on write
  assign thr_nxt = {{(THR_W-CFG_W){1'b0}}, cfg_wdata} *
                   {{(THR_W-MUL_W){1'b0}}, US_PER_MS};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_debounce_r <= ENC_DEBOUNCE_RST;
      press_thr_r    <= PRESS_THR_RST;
      switch_thr_r   <= SWITCH_THR_RST;
      power_thr_r    <= POWER_THR_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ENC_DEBOUNCE:   enc_debounce_r <= cfg_wdata;
        REG_PRESS_DEBOUNCE: press_thr_r    <= thr_nxt;
        REG_SWITCH_LONG:    switch_thr_r   <= thr_nxt;
        REG_POWER_LONG:     power_thr_r    <= thr_nxt;
        default: begin
        end
      endcase
    end
  end

  ebc_classify #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_classify (
    .cmd          (in_cmd_r),
    .level        (in_level_r),
    .now          (in_time_r),
    .last_pulse   (last_pulse_r),
    .sw_press     (sw_press_r),
    .pw_press     (pw_press_r),
    .stopped      (stopped_r),
    .enc_debounce (enc_debounce_r),
    .press_thr    (press_thr_r),
    .switch_thr   (switch_thr_r),
    .power_thr    (power_thr_r),
    .act          (act)
  );

  // stored times and stop flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pulse_r <= '0;
      sw_press_r   <= '0;
      pw_press_r   <= '0;
      stopped_r    <= 1'b0;
    end else if (adv) begin
      if (act.pulse_load) last_pulse_r <= in_time_r;
      if (act.sw_load) begin
        sw_press_r <= in_time_r;
      end else if (act.sw_clear) begin
        sw_press_r <= '0;
      end
      if (act.pw_load) begin
        pw_press_r <= in_time_r;
      end else if (act.pw_clear) begin
        pw_press_r <= '0;
      end
      if (act.stop) stopped_r <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= act.res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && act.res_valid) begin
      out_code_r  <= act.event_code;
      out_sleep_r <= act.sleep;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_code    = out_code_r;
  assign out_sleep_request = out_sleep_r;

  // checks
  `EBC_ASSERT(a_sleep_only_power_long, !(out_valid_r && out_sleep_r) || (out_code_r == EV_PWR_LONG), "sleep request without power long press")
  `EBC_ASSERT(a_no_result_when_stopped, !(stopped_r && act.res_valid), "result produced after stop")
  `EBC_ASSERT_NEXT(a_switch_release_clears, adv && !stopped_r && (in_cmd_r == CMD_SWITCH) && in_level_r, sw_press_r == '0, "switch press time not cleared on release")
  `EBC_ASSERT_NEXT(a_stop_sticks, stopped_r, stopped_r, "stop flag dropped before reset")

endmodule
